>>> design/mfpd_pkg.sv
// Shared types and constants of the marker follow PD controller.
package mfpd_pkg;

  localparam int unsigned COORD_W  = 16;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned DIST_W   = 17;
  localparam int unsigned ROOT_W   = 16;
  localparam int unsigned RAD_W    = 32;
  localparam int unsigned OPND_W   = 18;
  localparam int unsigned PROD_W   = 2 * OPND_W;
  localparam int unsigned Q_FRAC   = 12;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAR_LIMIT  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT = 8'd3;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd2048;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd410;
  localparam logic [GAIN_W-1:0] FAR_LIMIT_RST  = 16'd4506;
  localparam logic [GAIN_W-1:0] NEAR_LIMIT_RST = 16'd3686;

  localparam logic [1:0] ACT_FOLLOW = 2'd0;
  localparam logic [1:0] ACT_BACK   = 2'd1;
  localparam logic [1:0] ACT_STOP   = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SQ   = 5'b00010,
    ST_ROOT = 5'b00100,
    ST_PD   = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

>>> design/mfpd_mul.sv
// Shared signed multiplier with a registered product.
module mfpd_mul (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [mfpd_pkg::OPND_W-1:0] opnd_a,
  input  logic signed [mfpd_pkg::OPND_W-1:0] opnd_b,
  output logic signed [mfpd_pkg::PROD_W-1:0] prod
);
  import mfpd_pkg::*;

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= opnd_a * opnd_b;
    end
  end

  assign prod = prod_r;

endmodule

>>> design/mfpd_sqrt.sv
// Iterative integer square root, one result bit per cycle.
module mfpd_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [mfpd_pkg::RAD_W-1:0]   radicand,
  output logic [mfpd_pkg::ROOT_W-1:0]  root,
  output mfpd_pkg::sqrt_stat_t          stat
);
  import mfpd_pkg::*;

  localparam int unsigned REM_W = ROOT_W + 3;
  localparam int unsigned CNT_W = $clog2(ROOT_W);

  logic [RAD_W-1:0]  rad_r,  rad_nxt;
  logic [REM_W-1:0]  rem_r,  rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [CNT_W-1:0]  cnt_r,  cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;

  assign rem_sh = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};

  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CNT_W'(ROOT_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign root      = root_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

>>> design/marker_follow_pd_controller.sv
// Top level: sequencer, registers and result logic of the marker follow PD controller.
//
//  channel | handshake             | word
//  --------+-----------------------+-------------------------------------------
//  in      | in_valid / in_stall   | cam_x, cam_y, cam_z (signed Q4.12)
//  out     | out_valid / out_stall | forward_speed, turn_rate, action
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One word runs through these steps in order: the squares of the three coordinates on
// the shared multiplier, the bit-serial square root, the PD term on the multiplier,
// the result step, which waits while a stalled result is held, and back to idle.
// Words are taken only in idle. The square root loop is the longest step.
// Reset clears the registers to their defaults and the stored distance and turn.
// A stalled result is held in the output register; the next word is taken meanwhile.
module marker_follow_pd_controller (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [mfpd_pkg::COORD_W-1:0]  in_cam_x,
  input  logic signed [mfpd_pkg::COORD_W-1:0]  in_cam_y,
  input  logic signed [mfpd_pkg::COORD_W-1:0]  in_cam_z,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [mfpd_pkg::COORD_W-1:0] out_forward_speed,
  output logic signed [mfpd_pkg::COORD_W-1:0] out_turn_rate,
  output logic [1:0]                           out_action,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mfpd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mfpd_pkg::GAIN_W-1:0]          cfg_data
);
  import mfpd_pkg::*;

  localparam int unsigned PD_W = PROD_W - Q_FRAC;

  function automatic logic signed [COORD_W-1:0] sat16(input logic signed [PD_W:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > (PD_W+1)'(32767)) begin
      r = 16'sh7fff;
    end else if (v < -(PD_W+1)'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  state_t state_r, state_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  logic [GAIN_W-1:0] prop_gain_r, deriv_gain_r, far_limit_r, near_limit_r;

  logic signed [COORD_W-1:0] x_r, y_r, z_r;
  logic signed [PROD_W-1:0]  acc_r, acc_nxt;
  logic [DIST_W-1:0]         dist_r, dist_nxt;
  logic [DIST_W-1:0]         last_r, last_nxt;
  logic signed [COORD_W-1:0] held_r, held_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic signed [COORD_W-1:0] speed_r, speed_nxt;
  logic signed [COORD_W-1:0] turn_r, turn_nxt;
  logic [1:0]                action_r, action_nxt;

  logic                      in_acc;
  logic                      out_free;
  logic                      mul_en;
  logic signed [OPND_W-1:0]  opnd_a, opnd_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [OPND_W-1:0]  diff;
  logic                      sq_start;
  logic [ROOT_W-1:0]         sq_root;
  sqrt_stat_t                sq_stat;

  logic signed [PD_W-1:0]    pd;
  logic signed [PD_W:0]      pd_ext, pd_neg;
  logic                      is_far, is_near;
  logic signed [COORD_W-1:0] neg_x;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !(out_valid_r && out_stall);

  assign diff = $signed({1'b0, dist_r}) - $signed({1'b0, last_r});

  assign pd     = acc_r[PROD_W-1:Q_FRAC];
  assign pd_ext = {pd[PD_W-1], pd};
  assign pd_neg = -pd_ext;
  assign is_far  = dist_r > {1'b0, far_limit_r};
  assign is_near = dist_r < {1'b0, near_limit_r};
  assign neg_x   = (x_r == 16'sh8000) ? 16'sh7fff : -x_r;

  always_comb begin
    opnd_a = '0;
    opnd_b = '0;
    mul_en = 1'b0;
    case (state_r)
      ST_SQ: begin
        mul_en = (cnt_r != 2'd3);
        case (cnt_r)
          2'd0:    opnd_a = OPND_W'(x_r);
          2'd1:    opnd_a = OPND_W'(y_r);
          default: opnd_a = OPND_W'(z_r);
        endcase
        opnd_b = opnd_a;
      end
      ST_PD: begin
        mul_en = (cnt_r < 2'd2);
        if (cnt_r == 2'd0) begin
          opnd_a = $signed({2'b00, prop_gain_r});
          opnd_b = $signed({1'b0, dist_r});
        end else begin
          opnd_a = $signed({2'b00, deriv_gain_r});
          opnd_b = diff;
        end
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  mfpd_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .opnd_a (opnd_a),
    .opnd_b (opnd_b),
    .prod   (prod)
  );

  mfpd_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (acc_nxt[RAD_W-1:0]),
    .root     (sq_root),
    .stat     (sq_stat)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    dist_nxt      = dist_r;
    last_nxt      = last_r;
    held_nxt      = held_r;
    sq_start      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    speed_nxt     = speed_r;
    turn_nxt      = turn_r;
    action_nxt    = action_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_SQ;
          cnt_nxt   = '0;
          acc_nxt   = '0;
        end
      end
      ST_SQ: begin
        if (cnt_r != 2'd0) begin
          acc_nxt = acc_r + prod;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 2'd3) begin
          sq_start  = 1'b1;
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (sq_stat.done) begin
          dist_nxt  = DIST_W'(sq_root);
          acc_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_PD;
        end
      end
      ST_PD: begin
        if (cnt_r != 2'd0) begin
          acc_nxt = acc_r + prod;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 2'd2) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (is_far) begin
            speed_nxt  = sat16(pd_ext);
            turn_nxt   = neg_x;
            held_nxt   = neg_x;
            last_nxt   = dist_r;
            action_nxt = ACT_FOLLOW;
          end else if (is_near) begin
            speed_nxt  = sat16(pd_neg);
            turn_nxt   = held_r;
            last_nxt   = dist_r;
            action_nxt = ACT_BACK;
          end else begin
            speed_nxt  = '0;
            turn_nxt   = '0;
            held_nxt   = '0;
            action_nxt = ACT_STOP;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      last_r       <= '0;
      held_r       <= '0;
      prop_gain_r  <= PROP_GAIN_RST;
      deriv_gain_r <= DERIV_GAIN_RST;
      far_limit_r  <= FAR_LIMIT_RST;
      near_limit_r <= NEAR_LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
      held_r      <= held_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PROP_GAIN:  prop_gain_r  <= cfg_data;
          REG_DERIV_GAIN: deriv_gain_r <= cfg_data;
          REG_FAR_LIMIT:  far_limit_r  <= cfg_data;
          REG_NEAR_LIMIT: near_limit_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r <= in_cam_x;
      y_r <= in_cam_y;
      z_r <= in_cam_z;
    end
    acc_r    <= acc_nxt;
    dist_r   <= dist_nxt;
    speed_r  <= speed_nxt;
    turn_r   <= turn_nxt;
    action_r <= action_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_forward_speed = speed_r;
  assign out_turn_rate     = turn_r;
  assign out_action        = action_r;

  a_rise_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_OUT))
    else $error("result raised outside the result step");

  a_action_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_action == ACT_FOLLOW || out_action == ACT_BACK ||
                   out_action == ACT_STOP))
    else $error("result carries an unknown action");

  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_action == ACT_STOP) |->
      (out_forward_speed == '0 && out_turn_rate == '0))
    else $error("stop result with nonzero speed");

  a_sqrt_in_root: assert property (@(posedge clk) disable iff (!rst_n)
    sq_stat.busy |-> state_r == ST_ROOT)
    else $error("square root running outside its step");

endmodule

>>> dv/tb_top.sv
// Self-checking bench for the marker follow PD controller with queued stimulus and in-order checks.
`timescale 1ns / 100ps
module tb_top;
  import mfpd_pkg::*;

  localparam int IDLE_PCT       = 27;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PHASES  = 5;
  localparam int PHASE_WORDS    = 100;

  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_LO = REG_NEAR_LIMIT + 8'd1;
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_HI = '1;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } marker_t;

  typedef struct {
    logic signed [COORD_W-1:0] speed;
    logic signed [COORD_W-1:0] turn;
    logic [1:0]                action;
  } command_t;

  logic                        clk;
  logic                        rst_n     = 1'b0;
  logic                        in_valid  = 1'b0;
  logic                        in_stall;
  logic signed [COORD_W-1:0]   in_cam_x  = '0;
  logic signed [COORD_W-1:0]   in_cam_y  = '0;
  logic signed [COORD_W-1:0]   in_cam_z  = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [COORD_W-1:0]   out_forward_speed;
  logic signed [COORD_W-1:0]   out_turn_rate;
  logic [1:0]                  out_action;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [GAIN_W-1:0]           cfg_data  = '0;

  logic [GAIN_W-1:0]           kp_q        = PROP_GAIN_RST;
  logic [GAIN_W-1:0]           kd_q        = DERIV_GAIN_RST;
  logic [GAIN_W-1:0]           far_q       = FAR_LIMIT_RST;
  logic [GAIN_W-1:0]           near_q      = NEAR_LIMIT_RST;
  logic [DIST_W-1:0]           prev_dist   = '0;
  logic signed [COORD_W-1:0]   held_turn_q = '0;

  marker_t  markers_todo[$];
  command_t cmds_due[$];
  marker_t  word_held;
  int       words_queued = 0;
  int       words_taken  = 0;
  int       errors       = 0;
  int       quiet        = 0;
  logic     idling       = 1'b1;

  marker_follow_pd_controller u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cam_x          (in_cam_x),
    .in_cam_y          (in_cam_y),
    .in_cam_z          (in_cam_z),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_forward_speed (out_forward_speed),
    .out_turn_rate     (out_turn_rate),
    .out_action        (out_action),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned floor_root(input longint unsigned v);
    int unsigned root;
    int unsigned trial;
    root = 0;
    for (int b = 17; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (longint'(trial) * longint'(trial) <= v) root = trial;
    end
    return root;
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[COORD_W-1:0];
  endfunction

  task automatic predict_command(input marker_t m);
    longint unsigned   sq;
    logic [DIST_W-1:0] dist_v;
    longint            pd;
    command_t          c;
    sq = longint'(m.x) * longint'(m.x) + longint'(m.y) * longint'(m.y)
       + longint'(m.z) * longint'(m.z);
    dist_v = DIST_W'(floor_root(sq));
    c.speed = '0;
    c.turn  = '0;
    if (dist_v > far_q || dist_v < near_q) begin
      pd = (longint'(kp_q) * longint'(dist_v)
         + longint'(kd_q) * (longint'(dist_v) - longint'(prev_dist))) >>> Q_FRAC;
      prev_dist = dist_v;
      if (dist_v > far_q) begin
        c.speed     = clamp16(pd);
        c.turn      = clamp16(-longint'(m.x));
        held_turn_q = c.turn;
        c.action    = ACT_FOLLOW;
      end else begin
        c.speed  = clamp16(-pd);
        c.turn   = held_turn_q;
        c.action = ACT_BACK;
      end
    end else begin
      held_turn_q = '0;
      c.action    = ACT_STOP;
    end
    cmds_due.push_back(c);
  endtask

  task automatic flag(input string what);
    $display("ERROR at %0t: %s", $time, what);
    errors++;
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_command(word_held);
        words_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (markers_todo.size() != 0 && !(idling && $urandom_range(99) < IDLE_PCT)) begin
          word_held = markers_todo.pop_front();
          in_valid <= 1'b1;
          in_cam_x <= word_held.x;
          in_cam_y <= word_held.y;
          in_cam_z <= word_held.z;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    command_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (cmds_due.size() == 0) begin
          flag($sformatf("unexpected word speed=%0d turn=%0d action=%0d",
                         out_forward_speed, out_turn_rate, out_action));
        end else begin
          want = cmds_due.pop_front();
          if (out_forward_speed !== want.speed)
            flag($sformatf("forward_speed %0d, want %0d", out_forward_speed, want.speed));
          if (out_turn_rate !== want.turn)
            flag($sformatf("turn_rate %0d, want %0d", out_turn_rate, want.turn));
          if (out_action !== want.action)
            flag($sformatf("action %0d, want %0d", out_action, want.action));
        end
      end
      out_stall <= idling && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    case (idx)
      REG_PROP_GAIN:  kp_q   = val;
      REG_DERIV_GAIN: kd_q   = val;
      REG_FAR_LIMIT:  far_q  = val;
      REG_NEAR_LIMIT: near_q = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_all(input int kp, input int kd, input int far, input int near);
    write_reg(REG_PROP_GAIN, GAIN_W'(kp));
    write_reg(REG_DERIV_GAIN, GAIN_W'(kd));
    write_reg(REG_FAR_LIMIT, GAIN_W'(far));
    write_reg(REG_NEAR_LIMIT, GAIN_W'(near));
  endtask

  task automatic queue_marker(input int x, input int y, input int z);
    marker_t m;
    m.x = COORD_W'(x);
    m.y = COORD_W'(y);
    m.z = COORD_W'(z);
    markers_todo.push_back(m);
    words_queued++;
  endtask

  // hold until every word is back, then let the pipeline settle
  task automatic wait_drain();
    do @(negedge clk); while (words_taken != words_queued || cmds_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic queue_near_range(input int tgt);
    int     span;
    int     x;
    int     y;
    int     zm;
    longint rem;
    if (tgt < 0) tgt = 0;
    if (tgt > 56000) tgt = 56000;
    span = (tgt > 32767) ? 32767 : tgt;
    x = int'($urandom_range(span)) - span / 2;
    y = int'($urandom_range(span)) - span / 2;
    rem = longint'(tgt) * tgt - longint'(x) * x - longint'(y) * y;
    if (rem < 0) rem = 0;
    zm = int'(floor_root(rem)) + int'($urandom_range(4)) - 2;
    if (zm < 0) zm = 0;
    if (zm > 32767) zm = 32767;
    queue_marker(x, y, $urandom_range(1) ? -zm : zm);
  endtask

  task automatic run_random_phase();
    int far;
    int near;
    case ($urandom_range(3))
      0: set_all(PROP_GAIN_RST, DERIV_GAIN_RST, FAR_LIMIT_RST, NEAR_LIMIT_RST);
      1: set_all($urandom_range(65535), $urandom_range(65535),
                 $urandom_range(65535), $urandom_range(65535));
      default: begin
        far  = $urandom_range(60000);
        near = $urandom_range(far);
        set_all($urandom_range(8192), $urandom_range(8192), far, near);
      end
    endcase
    for (int i = 0; i < PHASE_WORDS; i++) begin
      case ($urandom_range(9))
        0, 1, 2: queue_marker($urandom() & 16'hFFFF, $urandom() & 16'hFFFF,
                              $urandom() & 16'hFFFF);
        3, 4, 5: queue_near_range(int'(far_q) + int'($urandom_range(16)) - 8);
        6, 7:    queue_near_range(int'(near_q) + int'($urandom_range(16)) - 8);
        default: queue_near_range($urandom_range(20000));
      endcase
    end
    wait_drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // defaults after reset
    queue_marker(0, 0, 0);
    queue_marker(0, 0, 4507);
    queue_marker(-32768, 0, 0);
    queue_marker(1000, 0, 2000);
    queue_marker(0, 0, 4506);
    queue_marker(0, 3686, 0);
    queue_marker(0, 0, -3685);
    queue_marker(32767, 32767, 32767);
    queue_marker(-32768, -32768, -32768);
    queue_marker(-32768, -32768, -32768);
    queue_marker(0, 0, 4507);
    queue_marker(100, -200, 300);
    queue_marker(4000, 0, 0);
    queue_marker(5000, 0, 0);
    queue_marker(-1, -1, -1);
    queue_marker(0, -32768, 0);
    queue_marker(12345, -23456, 3456);
    wait_drain();

    // top of every register, then writes to unused indexes that must not land
    set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    write_reg(IDX_UNUSED_LO, '0);
    write_reg(IDX_UNUSED_HI, '0);
    queue_marker(-32768, -32768, -32768);
    queue_marker(0, 0, 0);
    queue_marker(-32768, 0, 0);
    wait_drain();

    set_all(0, 0, 0, 0);
    queue_marker(0, 0, 0);
    queue_marker(0, 0, 1);
    queue_marker(-32768, 5, 5);
    queue_marker(32767, 0, 0);
    wait_drain();

    // near above far: follow wins
    set_all(4096, 8192, 20000, 40000);
    queue_marker(0, 0, 30000);
    queue_marker(0, 0, 10000);
    queue_marker(0, 0, 20000);
    queue_marker(0, 0, -32768);
    wait_drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      idling = (p != 2);
      run_random_phase();
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> files.f
design/mfpd_pkg.sv
design/mfpd_mul.sv
design/mfpd_sqrt.sv
design/marker_follow_pd_controller.sv
dv/tb_top.sv
